// File: rtl/ntps_pkg.sv
// Package: shared constants, payload structs and controller/datapath command types.
package ntps_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam logic [15:0] NoAddr = 16'hFFFF;
	localparam logic [15:0] MaxCost = 16'hFFFF;
	localparam logic [15:0] LinkOffset = 16'd10;

	localparam logic [1:0] CfgMyAddr = 2'd0;
	localparam logic [1:0] CfgIsRoot = 2'd1;
	localparam logic [1:0] CfgThresh = 2'd2;
	localparam logic [1:0] CfgEcn = 2'd3;

	localparam logic [2:0] FnBeacon = 3'd0;
	localparam logic [2:0] FnEvict = 3'd1;
	localparam logic [2:0] FnQuality = 3'd2;
	localparam logic [2:0] FnCongest = 3'd3;
	localparam logic [2:0] FnQuery = 3'd4;
	localparam logic [2:0] FnRecompute = 3'd5;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StNotFound = 2'd2;
	localparam logic [1:0] StInvalid = 2'd3;

	localparam logic [1:0] EvNone = 2'd0;
	localparam logic [1:0] EvFound = 2'd1;
	localparam logic [1:0] EvLost = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		logic [15:0] neighbor_addr;
		logic [15:0] parent_addr;
		logic [15:0] path_etx;
		logic [15:0] link_quality;
		logic congested;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic insert_advised;
		logic [15:0] route_parent;
		logic has_route;
		logic [15:0] advertised_etx;
		logic [1:0] route_event;
		logic parent_changed;
		logic [4:0] neighbor_count;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture the item, clear scan state
		logic scan;      // examine entry at scan index, advance
		logic finish;    // apply the operation after the scan
		logic shift;     // move entry idx+1 to idx during eviction
		logic report;    // form the result
	} cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic scan_done;
		logic shift_done;
	} stat_t;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? MaxCost : s[15:0];
	endfunction

endpackage

// File: rtl/ntps_ctrl.sv
// Controller: sequences load, table scan, finish, eviction shift and report for one item.
module ntps_ctrl import ntps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input stat_t stat,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_FIN = 5'b00100,
		S_SHIFT = 5'b01000,
		S_RPT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_done) state_d = S_RPT;
			end
			S_RPT: begin
				cmd.report = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// File: rtl/ntps_dp.sv
// Datapath: neighbor table, route registers, scan logic and result formation.
module ntps_dp import ntps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input item_t item,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	output stat_t stat,
	output logic done,
	output result_t result
);

	logic [15:0] nb_q [TableDepth];
	logic [15:0] par_q [TableDepth];
	logic [15:0] cost_q [TableDepth];
	logic [15:0] qual_q [TableDepth];
	logic cg_q [TableDepth];

	logic [CntW-1:0] count_q;
	logic [15:0] cur_par_q, cur_cost_q, my_addr_q, thresh_q;
	logic cur_cg_q, evicted_q, root_q, ecn_q;

	item_t it_q;
	logic [CntW-1:0] sidx_q;
	logic found_q, pfound_q, adv_q, have_best_q, chg_q;
	logic [IdxW-1:0] fidx_q, pidx_q, bidx_q;
	logic [15:0] min_q, curetx_q, rc_cost_q;
	logic rc_cg_q;
	logic [1:0] st_q, ev_q;

	logic [IdxW-1:0] si;
	logic [15:0] path;
	assign si = sidx_q[IdxW-1:0];
	assign path = sat_add(sat_add(qual_q[si], LinkOffset), cost_q[si]);
	assign stat.scan_done = (sidx_q + 1'b1 >= count_q) || (count_q == '0);
	assign stat.shift_done = !(it_q.func == FnEvict && found_q) ||
		({1'b0, fidx_q} >= count_q);

	logic rc_switch;
	always_comb begin
		rc_switch = 1'b0;
		if (min_q != MaxCost && have_best_q)
			rc_switch = (curetx_q == MaxCost) ||
				(rc_cg_q && min_q < sat_add(rc_cost_q, LinkOffset)) ||
				(sat_add(min_q, thresh_q) < curetx_q);
	end

	logic [IdxW-1:0] widx;
	logic do_write;
	always_comb begin
		widx = found_q ? fidx_q : count_q[IdxW-1:0];
		do_write = !found_q && (count_q < CntW'(TableDepth));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= item;
		if (cmd.finish) begin
			case (it_q.func)
				FnBeacon: if (it_q.parent_addr != NoAddr) begin
					if (found_q || do_write) begin
						nb_q[widx] <= it_q.neighbor_addr;
						par_q[widx] <= it_q.parent_addr;
						cost_q[widx] <= it_q.path_etx;
						qual_q[widx] <= it_q.link_quality;
						cg_q[widx] <= (ecn_q && it_q.neighbor_addr != NoAddr) ?
							it_q.congested : (found_q ? cg_q[widx] : 1'b0);
					end
				end
				FnQuality: if (found_q) qual_q[fidx_q] <= it_q.link_quality;
				FnCongest: if (ecn_q && found_q) cg_q[fidx_q] <= it_q.congested;
				default: ;
			endcase
		end
		if (cmd.shift && !stat.shift_done) begin
			nb_q[fidx_q] <= nb_q[fidx_q + 1'b1];
			par_q[fidx_q] <= par_q[fidx_q + 1'b1];
			cost_q[fidx_q] <= cost_q[fidx_q + 1'b1];
			qual_q[fidx_q] <= qual_q[fidx_q + 1'b1];
			cg_q[fidx_q] <= cg_q[fidx_q + 1'b1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; cur_par_q <= NoAddr; cur_cost_q <= '0; cur_cg_q <= 1'b0;
			evicted_q <= 1'b0; my_addr_q <= '0; root_q <= 1'b0; thresh_q <= 16'd15;
			ecn_q <= 1'b0; sidx_q <= '0; found_q <= 1'b0; pfound_q <= 1'b0;
			adv_q <= 1'b0; have_best_q <= 1'b0; chg_q <= 1'b0; fidx_q <= '0;
			pidx_q <= '0; bidx_q <= '0; min_q <= MaxCost; curetx_q <= MaxCost;
			rc_cost_q <= '0; rc_cg_q <= 1'b0; st_q <= StOk; ev_q <= EvNone;
			done <= 1'b0; result <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CfgMyAddr: my_addr_q <= cfg_data;
					CfgIsRoot: begin
						root_q <= cfg_data[0];
						cur_cost_q <= '0;
						if (cfg_data[0]) cur_par_q <= my_addr_q;
						else begin cur_par_q <= NoAddr; cur_cg_q <= 1'b0; end
					end
					CfgThresh: thresh_q <= cfg_data;
					CfgEcn: ecn_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				sidx_q <= '0; found_q <= 1'b0; pfound_q <= 1'b0; adv_q <= 1'b0;
				have_best_q <= 1'b0; chg_q <= 1'b0; min_q <= MaxCost;
				curetx_q <= MaxCost; rc_cost_q <= cur_cost_q; rc_cg_q <= cur_cg_q;
				st_q <= StOk; ev_q <= EvNone;
			end
			if (cmd.scan && count_q != '0) begin
				sidx_q <= sidx_q + 1'b1;
				if (!found_q && it_q.neighbor_addr != NoAddr &&
					nb_q[si] == it_q.neighbor_addr) begin
					found_q <= 1'b1; fidx_q <= si;
				end
				if (!pfound_q && cur_par_q != NoAddr && nb_q[si] == cur_par_q) begin
					pfound_q <= 1'b1; pidx_q <= si;
				end
				if (nb_q[si] != cur_par_q && it_q.path_etx < cost_q[si]) adv_q <= 1'b1;
				if (par_q[si] != NoAddr && par_q[si] != my_addr_q) begin
					if (nb_q[si] == cur_par_q) begin
						curetx_q <= path; rc_cost_q <= cost_q[si]; rc_cg_q <= cg_q[si];
					end else if (!cg_q[si] && path < min_q) begin
						min_q <= path; bidx_q <= si; have_best_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				case (it_q.func)
					FnBeacon: begin
						if (it_q.parent_addr == NoAddr) st_q <= StInvalid;
						else if (!found_q) begin
							if (do_write) count_q <= count_q + 1'b1;
							else st_q <= StFull;
						end
					end
					FnEvict: begin
						if (!found_q) st_q <= StNotFound;
						else count_q <= count_q - 1'b1;
						if (!root_q && cur_par_q == it_q.neighbor_addr) begin
							cur_par_q <= NoAddr; cur_cost_q <= '0; cur_cg_q <= 1'b0;
							evicted_q <= 1'b1;
						end
					end
					FnQuality: if (!found_q) st_q <= StNotFound;
					FnCongest: if (ecn_q && !found_q) st_q <= StNotFound;
					FnQuery: begin
						if (it_q.parent_addr == NoAddr) begin
							st_q <= StInvalid; adv_q <= 1'b0;
						end else if (it_q.path_etx == '0) adv_q <= 1'b1;
					end
					FnRecompute: if (!root_q) begin
						if (rc_switch) begin
							cur_par_q <= nb_q[bidx_q]; cur_cost_q <= cost_q[bidx_q];
							cur_cg_q <= cg_q[bidx_q]; chg_q <= 1'b1;
							pfound_q <= 1'b1; pidx_q <= bidx_q;
						end else begin
							cur_cost_q <= rc_cost_q; cur_cg_q <= rc_cg_q;
						end
						if (evicted_q && !rc_switch && cur_par_q == NoAddr) ev_q <= EvLost;
						else if (!evicted_q && curetx_q == MaxCost && min_q != MaxCost)
							ev_q <= EvFound;
						evicted_q <= 1'b0;
					end
					default: ;
				endcase
				// Re-scan is avoided: parent position after table changes is tracked below.
				if (it_q.func == FnEvict && found_q && pfound_q && fidx_q < pidx_q)
					pidx_q <= pidx_q - 1'b1;
				if (it_q.func == FnBeacon && it_q.parent_addr != NoAddr && !found_q &&
					do_write && it_q.neighbor_addr == cur_par_q && !pfound_q) begin
					pfound_q <= 1'b1; pidx_q <= count_q[IdxW-1:0];
				end
			end
			if (cmd.shift && !stat.shift_done) fidx_q <= fidx_q + 1'b1;
			if (cmd.report) begin
				done <= 1'b1;
				result.status <= st_q;
				result.insert_advised <= (it_q.func == FnQuery) ? adv_q : 1'b0;
				result.route_event <= ev_q;
				result.parent_changed <= chg_q;
				result.neighbor_count <= 5'(count_q);
				if (root_q) begin
					result.route_parent <= my_addr_q; result.has_route <= 1'b1;
					result.advertised_etx <= '0;
				end else begin
					result.route_parent <= cur_par_q;
					result.has_route <= (cur_par_q != NoAddr);
					result.advertised_etx <= (cur_par_q != NoAddr && pfound_q) ?
						sat_add(cur_cost_q, sat_add(qual_q[pidx_q], LinkOffset)) : MaxCost;
				end
			end
		end
	end

endmodule

// File: rtl/neighbor_table_parent_selector.sv
// Top level: neighbor table and parent selector, controller plus datapath.
// Each item passes through load, table scan, finish, eviction shift and report; done is registered from report.
// Throughput: one item at a time; the table scan examines one entry per cycle.
// An eviction moves each later entry down one place during the shift.
// Reset: arst_n clears the table count, route registers and configuration to reset values.
// The result is strobed by done for one cycle; the receiver cannot stall.
module neighbor_table_parent_selector import ntps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input item_t item,
	output logic busy,
	output logic done,
	output result_t result,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data
);

	cmd_t cmd;
	stat_t stat;
	logic ctrl_busy;

	ntps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .busy(ctrl_busy), .cmd(cmd)
	);

	ntps_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(item), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data), .stat(stat), .done(done), .result(result)
	);

	assign busy = ctrl_busy;

endmodule

// File: tb/sv/tb_neighbor_table_parent_selector.sv
// Testbench for the neighbour table and parent selector: directed table, table overflow, then random traffic.
module tb_neighbor_table_parent_selector;
	timeunit 1ns;
	timeprecision 1ps;
	import ntps_pkg::*;

	localparam int WatchLimit = 20000;

	logic clk;
	logic arst_n;
	logic start;
	item_t item;
	logic busy;
	logic done;
	result_t result;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;

	neighbor_table_parent_selector u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Predicted table and route state.
	logic [15:0] nb_addr [TableDepth];
	logic [15:0] nb_parent [TableDepth];
	logic [15:0] nb_cost [TableDepth];
	logic [15:0] nb_quality [TableDepth];
	logic nb_congested [TableDepth];
	int nb_count;
	logic [15:0] par_addr;
	logic [15:0] par_cost;
	logic par_congested;
	logic evicted_flag;
	logic [15:0] own_addr;
	logic root_mode;
	logic [15:0] hysteresis;
	logic ecn_on;

	result_t pending_results[$];
	int mismatches;
	int transfers_in;
	int results_seen;
	int idle_cycles;
	logic quiet;

	typedef struct {
		item_t stim;
		logic fixed;
		result_t answer;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] cost_sum(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic int locate(input logic [15:0] a);
		if (a == NoAddr) begin
			return nb_count;
		end
		for (int i = 0; i < nb_count; i++) begin
			if (nb_addr[i] == a) begin
				return i;
			end
		end
		return nb_count;
	endfunction

	function automatic void predict_register(input logic [1:0] idx, input logic [15:0] v);
		case (idx)
			CfgMyAddr: begin
				own_addr = v;
			end
			CfgIsRoot: begin
				root_mode = v[0];
				if (root_mode) begin
					par_addr = own_addr;
					par_cost = 16'd0;
				end else begin
					par_addr = NoAddr;
					par_cost = 16'd0;
					par_congested = 1'b0;
				end
			end
			CfgThresh: begin
				hysteresis = v;
			end
			default: begin
				ecn_on = v[0];
			end
		endcase
	endfunction

	function automatic void reselect_parent(output logic [1:0] ev, output logic chg);
		logic [15:0] best_path;
		logic [15:0] cur_path;
		logic [15:0] p;
		int best;
		logic found;
		best_path = 16'hFFFF;
		cur_path = 16'hFFFF;
		best = 0;
		found = 1'b0;
		ev = EvNone;
		chg = 1'b0;
		for (int i = 0; i < nb_count; i++) begin
			if (nb_parent[i] == NoAddr || nb_parent[i] == own_addr) begin
				continue;
			end
			p = cost_sum(cost_sum(nb_quality[i], LinkOffset), nb_cost[i]);
			if (nb_addr[i] == par_addr) begin
				cur_path = p;
				par_cost = nb_cost[i];
				par_congested = nb_congested[i];
				continue;
			end
			if (nb_congested[i]) begin
				continue;
			end
			if (p < best_path) begin
				best_path = p;
				best = i;
				found = 1'b1;
			end
		end
		if (best_path != 16'hFFFF && found) begin
			if (cur_path == 16'hFFFF
					|| (par_congested && best_path < cost_sum(par_cost, LinkOffset))
					|| cost_sum(best_path, hysteresis) < cur_path) begin
				par_addr = nb_addr[best];
				par_cost = nb_cost[best];
				par_congested = nb_congested[best];
				chg = 1'b1;
			end
		end
		if (evicted_flag && par_addr == NoAddr) begin
			ev = EvLost;
		end else if (!evicted_flag && cur_path == 16'hFFFF && best_path != 16'hFFFF) begin
			ev = EvFound;
		end
		evicted_flag = 1'b0;
	endfunction

	function automatic result_t predict_route(input item_t it);
		result_t r;
		int k;
		logic [1:0] ev;
		logic chg;
		r = '0;
		case (it.func)
			FnBeacon: begin
				if (it.parent_addr == NoAddr) begin
					r.status = StInvalid;
				end else begin
					k = locate(it.neighbor_addr);
					if (k < nb_count) begin
						nb_parent[k] = it.parent_addr;
						nb_cost[k] = it.path_etx;
						nb_quality[k] = it.link_quality;
					end else if (nb_count >= TableDepth) begin
						r.status = StFull;
					end else begin
						nb_addr[nb_count] = it.neighbor_addr;
						nb_parent[nb_count] = it.parent_addr;
						nb_cost[nb_count] = it.path_etx;
						nb_quality[nb_count] = it.link_quality;
						nb_congested[nb_count] = 1'b0;
						nb_count++;
					end
					if (ecn_on) begin
						k = locate(it.neighbor_addr);
						if (k < nb_count) begin
							nb_congested[k] = it.congested;
						end
					end
				end
			end
			FnEvict: begin
				k = locate(it.neighbor_addr);
				if (k >= nb_count) begin
					r.status = StNotFound;
				end else begin
					nb_count--;
					for (int i = k; i < nb_count; i++) begin
						nb_addr[i] = nb_addr[i + 1];
						nb_parent[i] = nb_parent[i + 1];
						nb_cost[i] = nb_cost[i + 1];
						nb_quality[i] = nb_quality[i + 1];
						nb_congested[i] = nb_congested[i + 1];
					end
				end
				if (!root_mode && par_addr == it.neighbor_addr) begin
					par_addr = NoAddr;
					par_cost = 16'd0;
					par_congested = 1'b0;
					evicted_flag = 1'b1;
				end
			end
			FnQuality: begin
				k = locate(it.neighbor_addr);
				if (k < nb_count) begin
					nb_quality[k] = it.link_quality;
				end else begin
					r.status = StNotFound;
				end
			end
			FnCongest: begin
				if (ecn_on) begin
					k = locate(it.neighbor_addr);
					if (k < nb_count) begin
						nb_congested[k] = it.congested;
					end else begin
						r.status = StNotFound;
					end
				end
			end
			FnQuery: begin
				if (it.parent_addr == NoAddr) begin
					r.status = StInvalid;
				end else if (it.path_etx == 16'd0) begin
					r.insert_advised = 1'b1;
				end else begin
					for (int i = 0; i < nb_count; i++) begin
						if (nb_addr[i] != par_addr && it.path_etx < nb_cost[i]) begin
							r.insert_advised = 1'b1;
							break;
						end
					end
				end
			end
			FnRecompute: begin
				if (!root_mode) begin
					reselect_parent(ev, chg);
					r.route_event = ev;
					r.parent_changed = chg;
				end
			end
			default: begin
			end
		endcase
		if (root_mode) begin
			r.route_parent = own_addr;
			r.has_route = 1'b1;
			r.advertised_etx = 16'd0;
		end else begin
			r.route_parent = par_addr;
			r.has_route = par_addr != NoAddr;
			r.advertised_etx = 16'hFFFF;
			if (r.has_route) begin
				k = locate(par_addr);
				if (k < nb_count) begin
					r.advertised_etx = cost_sum(par_cost, cost_sum(nb_quality[k], LinkOffset));
				end
			end
		end
		r.neighbor_count = nb_count[4:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t w;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("mismatch: result with nothing outstanding");
				mismatches++;
			end else begin
				w = pending_results.pop_front();
				if (result.status !== w.status)
					report_mismatch("status", result.status, w.status);
				if (result.insert_advised !== w.insert_advised)
					report_mismatch("insert_advised", result.insert_advised, w.insert_advised);
				if (result.route_parent !== w.route_parent)
					report_mismatch("route_parent", result.route_parent, w.route_parent);
				if (result.has_route !== w.has_route)
					report_mismatch("has_route", result.has_route, w.has_route);
				if (result.advertised_etx !== w.advertised_etx)
					report_mismatch("advertised_etx", result.advertised_etx, w.advertised_etx);
				if (result.route_event !== w.route_event)
					report_mismatch("route_event", result.route_event, w.route_event);
				if (result.parent_changed !== w.parent_changed)
					report_mismatch("parent_changed", result.parent_changed, w.parent_changed);
				if (result.neighbor_count !== w.neighbor_count)
					report_mismatch("neighbor_count", result.neighbor_count, w.neighbor_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_item(input item_t it, input logic fixed, input result_t answer);
		result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		while (busy) begin
			@(negedge clk);
		end
		item <= it;
		start <= 1'b1;
		r = predict_route(it);
		if (fixed && r !== answer) begin
			$display("mismatch: directed row disagrees with prediction");
			mismatches++;
		end
		pending_results.push_back(r);
		transfers_in++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (2 * TableDepth + 8) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		predict_register(idx, v);
	endtask

	function automatic item_t make_item(input logic [2:0] f, input logic [15:0] n,
			input logic [15:0] p, input logic [15:0] e, input logic [15:0] q, input logic c);
		item_t it;
		it.func = f;
		it.neighbor_addr = n;
		it.parent_addr = p;
		it.path_etx = e;
		it.link_quality = q;
		it.congested = c;
		return it;
	endfunction

	function automatic result_t idle_answer(input logic [1:0] st, input logic [4:0] cnt);
		result_t r;
		r = '0;
		r.status = st;
		r.route_parent = NoAddr;
		r.advertised_etx = 16'hFFFF;
		r.neighbor_count = cnt;
		return r;
	endfunction

	function automatic item_t random_item(input int pool);
		item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		it.neighbor_addr = (pool > 0) ? 16'(100 + $urandom_range(0, pool)) : 16'($urandom);
		if ($urandom_range(0, 20) == 0)
			it.neighbor_addr = NoAddr;
		it.parent_addr = ($urandom_range(0, 9) == 0) ? NoAddr :
			($urandom_range(0, 9) == 0) ? own_addr : 16'($urandom_range(0, 40));
		it.path_etx = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 300));
		it.link_quality = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 100));
		it.congested = 1'($urandom);
		if (sel < 35) it.func = FnBeacon;
		else if (sel < 45) it.func = FnEvict;
		else if (sel < 55) it.func = FnQuality;
		else if (sel < 63) it.func = FnCongest;
		else if (sel < 73) it.func = FnQuery;
		else if (sel < 97) it.func = FnRecompute;
		else it.func = 3'($urandom_range(6, 7));
		return it;
	endfunction

	row_t rows[$];

	initial begin
		row_t rw;
		int pool;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = CfgMyAddr;
		cfg_data = 16'd0;
		quiet = 1'b0;
		mismatches = 0;
		transfers_in = 0;
		results_seen = 0;
		idle_cycles = 0;
		nb_count = 0;
		par_addr = NoAddr;
		par_cost = 16'd0;
		par_congested = 1'b0;
		evicted_flag = 1'b0;
		own_addr = 16'd0;
		root_mode = 1'b0;
		hysteresis = 16'd15;
		ecn_on = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rw = '{make_item(FnRecompute, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1,
			idle_answer(StOk, 5'd0)};
		rows.push_back(rw);
		rw = '{make_item(FnBeacon, 16'd1, NoAddr, 16'd5, 16'd5, 1'b1), 1'b1,
			idle_answer(StInvalid, 5'd0)};
		rows.push_back(rw);
		rw = '{make_item(FnEvict, 16'd7, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1,
			idle_answer(StNotFound, 5'd0)};
		rows.push_back(rw);
		rw = '{make_item(FnQuality, 16'd7, 16'd0, 16'd0, 16'hFFFF, 1'b0), 1'b1,
			idle_answer(StNotFound, 5'd0)};
		rows.push_back(rw);
		rw = '{make_item(FnQuery, 16'd7, 16'd3, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnBeacon, 16'hFFFF, 16'd9, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnBeacon, 16'd0, 16'd9, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnBeacon, 16'd20, 16'd9, 16'd100, 16'd20, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnBeacon, 16'd21, 16'd0, 16'd30, 16'd5, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnRecompute, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnQuery, 16'd5, 16'd2, 16'd50, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnQuery, 16'd5, NoAddr, 16'd50, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnCongest, 16'd20, 16'd0, 16'd0, 16'd0, 1'b1), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnQuality, 16'd20, 16'd0, 16'd0, 16'd1, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnRecompute, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnEvict, 16'd20, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnEvict, 16'd21, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		rw = '{make_item(FnRecompute, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0};
		rows.push_back(rw);
		foreach (rows[i]) begin
			send_item(rows[i].stim, rows[i].fixed, rows[i].answer);
		end

		// Fill the table to overflow with ECN on and a zero margin.
		drain_results();
		write_register(CfgEcn, 16'd1);
		write_register(CfgThresh, 16'd0);
		for (int i = 0; i < TableDepth + 2; i++) begin
			send_item(make_item(FnBeacon, 16'(200 + i), 16'(i), 16'(i * 7), 16'(i), 1'(i)),
				1'b0, '0);
		end
		send_item(make_item(FnBeacon, 16'd205, 16'd3, 16'd1, 16'd1, 1'b1), 1'b0, '0);
		send_item(make_item(FnCongest, 16'd201, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0);
		send_item(make_item(FnRecompute, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, '0);

		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase)
				1: write_register(CfgMyAddr, 16'd5);
				2: write_register(CfgIsRoot, 16'd1);
				3: write_register(CfgIsRoot, 16'd0);
				4: write_register(CfgThresh, 16'hFFFF);
				5: write_register(CfgEcn, 16'd0);
				6: write_register(CfgMyAddr, 16'hFFFE);
				7: write_register(CfgThresh, 16'd15);
				default: write_register(CfgThresh, 16'($urandom_range(0, 40)));
			endcase
			if (phase == 6)
				write_register(CfgEcn, 16'd1);
			if (phase == 7)
				quiet = 1'b1;
			pool = (phase % 2 == 0) ? 24 : 12;
			for (int n = 0; n < 100; n++) begin
				send_item(random_item(pool), 1'b0, '0);
			end
		end

		drain_results();
		$display("%0d items sent and %0d results checked over eight register settings,",
			transfers_in, results_seen);
		$display("covering table overflow, eviction of the parent, root mode and hysteresis.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/ntps_pkg.sv
rtl/ntps_ctrl.sv
rtl/ntps_dp.sv
rtl/neighbor_table_parent_selector.sv
tb/sv/tb_neighbor_table_parent_selector.sv
